// ===== hw/rtl/fotsw_pkg.sv =====
`timescale 1ns / 1ps

package fotsw_pkg;

   localparam int NUM_DIRECT        = 8;
   localparam int ENTRIES_PER_TABLE = 32;
   localparam int SECTOR_BYTES      = 128;
   localparam int NUM_SECTORS       = 1024;

   localparam int MODE_W = 2;
   localparam int SLOT_W = 4;
   localparam int SEC_W  = 10;
   localparam int ENT_W  = 5;
   localparam int OFF_W  = 18;
   localparam int LVL_W  = 2;

   localparam int HDR_DEPTH   = NUM_DIRECT + 2;
   localparam int HDR_W       = $clog2(HDR_DEPTH);
   localparam int SINGLE_SLOT = NUM_DIRECT;
   localparam int DOUBLE_SLOT = NUM_DIRECT + 1;

   localparam int SEC_IDX_W   = $clog2(NUM_SECTORS);
   localparam int ENT_IDX_W   = $clog2(ENTRIES_PER_TABLE);
   localparam int ADDR_W      = SEC_IDX_W + ENT_IDX_W;
   localparam int STORE_DEPTH = NUM_SECTORS * ENTRIES_PER_TABLE;

   localparam int SB_SHIFT   = $clog2(SECTOR_BYTES);
   localparam int SPAN_SHIFT = SB_SHIFT + ENT_IDX_W;

   localparam int DIRECT_SZ = NUM_DIRECT * SECTOR_BYTES;
   localparam int SINGLE_SZ = DIRECT_SZ + ENTRIES_PER_TABLE * SECTOR_BYTES;
   localparam int DOUBLE_SZ = SINGLE_SZ
                              + ENTRIES_PER_TABLE * ENTRIES_PER_TABLE * SECTOR_BYTES;

   localparam logic [MODE_W-1:0] MODE_HDR_WR = 2'd0;
   localparam logic [MODE_W-1:0] MODE_IDX_WR = 2'd1;
   localparam logic [MODE_W-1:0] MODE_XLATE  = 2'd2;

   localparam logic [LVL_W-1:0] LVL_DIRECT = 2'd0;
   localparam logic [LVL_W-1:0] LVL_SINGLE = 2'd1;
   localparam logic [LVL_W-1:0] LVL_DOUBLE = 2'd2;

   localparam int JOBQ_DEPTH = 4;
   localparam int JOBQ_PTR_W = $clog2(JOBQ_DEPTH);
   localparam int RSPQ_DEPTH = 4;
   localparam int RSPQ_PTR_W = $clog2(RSPQ_DEPTH);

   typedef enum logic [1:0] {
      OP_WRITE,
      OP_DIRECT,
      OP_SINGLE,
      OP_DOUBLE
   } op_type;

   typedef struct packed {
      op_type                 op;
      logic [LVL_W-1:0]       level;
      logic                   oor;
      logic [ADDR_W-1:0]      addr;
      logic [ENT_IDX_W-1:0]   inner;
      logic [SEC_W-1:0]       data;
   } job_type;

   typedef struct packed {
      logic [SEC_W-1:0] sector;
      logic [LVL_W-1:0] level;
      logic             oor;
   } rsp_type;

endpackage

// ===== hw/rtl/file_offset_to_sector_walker_core.sv =====
`timescale 1ns / 1ps

// Maps a file byte offset to its disk sector through a header of eight direct
// slots plus single and double indirect table pointers, and an index store of
// 32 ten-bit words per sector. Header writes (mode 0) take effect as the beat
// is accepted; index writes (mode 1) and translations (mode 2) pass through a
// four-deep job queue to a walker that owns a single-port index memory with
// registered read data. Only translations return a result. Writes, direct and
// out-of-range lookups and single indirect lookups issue one per cycle while
// the result queue has room and no double walk holds the port; a double
// indirect lookup holds the memory port for a second read, addressed by the
// data of its first. A job passes through the job queue, the memory read and
// stage registers, and the result queue before it shows on the result ports.
// A four-deep result queue lets the input side keep going while results wait.
// Index entries have no reset value and must be written before they are read.
module file_offset_to_sector_walker_core (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_push,
   output logic                         req_full,
   input  logic [fotsw_pkg::MODE_W-1:0] req_mode,
   input  logic [fotsw_pkg::SLOT_W-1:0] req_header_slot,
   input  logic [fotsw_pkg::SEC_W-1:0]  req_table_sector,
   input  logic [fotsw_pkg::ENT_W-1:0]  req_table_entry,
   input  logic [fotsw_pkg::SEC_W-1:0]  req_sector_value,
   input  logic [fotsw_pkg::OFF_W-1:0]  req_byte_offset,
   output logic                         rsp_empty,
   input  logic                         rsp_pop,
   output logic [fotsw_pkg::SEC_W-1:0]  rsp_sector,
   output logic [fotsw_pkg::LVL_W-1:0]  rsp_level,
   output logic                         rsp_out_of_range
);
   import fotsw_pkg::*;

   logic    jobq_full;
   logic    jobq_push;
   job_type jobq_job;
   logic    head_valid;
   job_type head_job;
   logic    head_pop;

   fotsw_front u_front (
      .clock            (clock),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_mode         (req_mode),
      .req_header_slot  (req_header_slot),
      .req_table_sector (req_table_sector),
      .req_table_entry  (req_table_entry),
      .req_sector_value (req_sector_value),
      .req_byte_offset  (req_byte_offset),
      .jobq_full        (jobq_full),
      .jobq_push        (jobq_push),
      .jobq_job         (jobq_job)
   );

   fotsw_job_queue u_job_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (jobq_push),
      .push_job   (jobq_job),
      .full       (jobq_full),
      .pop        (head_pop),
      .head_valid (head_valid),
      .head_job   (head_job)
   );

   fotsw_back u_back (
      .clock            (clock),
      .reset            (reset),
      .job_valid        (head_valid),
      .job              (head_job),
      .job_pop          (head_pop),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_sector       (rsp_sector),
      .rsp_level        (rsp_level),
      .rsp_out_of_range (rsp_out_of_range)
   );

endmodule

// ===== hw/rtl/fotsw_front.sv =====
`timescale 1ns / 1ps

module fotsw_front (
   input  logic                          clock,
   input  logic                          req_push,
   output logic                          req_full,
   input  logic [fotsw_pkg::MODE_W-1:0]  req_mode,
   input  logic [fotsw_pkg::SLOT_W-1:0]  req_header_slot,
   input  logic [fotsw_pkg::SEC_W-1:0]   req_table_sector,
   input  logic [fotsw_pkg::ENT_W-1:0]   req_table_entry,
   input  logic [fotsw_pkg::SEC_W-1:0]   req_sector_value,
   input  logic [fotsw_pkg::OFF_W-1:0]   req_byte_offset,
   input  logic                          jobq_full,
   output logic                          jobq_push,
   output fotsw_pkg::job_type            jobq_job
);
   import fotsw_pkg::*;

   logic [SEC_W-1:0]     hdr_ff [HDR_DEPTH];
   logic                 accept;
   logic [OFF_W-1:0]     rel_single;
   logic [OFF_W-1:0]     rel_double;
   logic [HDR_W-1:0]     dir_idx;
   logic [ENT_IDX_W-1:0] sgl_idx;
   logic [ENT_IDX_W-1:0] dbl_outer;
   logic [ENT_IDX_W-1:0] dbl_inner;
   logic [SEC_W-1:0]     sgl_ptr;
   logic [SEC_W-1:0]     dbl_ptr;
   logic                 hdr_we;

   assign req_full = jobq_full;
   assign accept   = req_push & ~jobq_full;

   assign rel_single = req_byte_offset - OFF_W'(DIRECT_SZ);
   assign rel_double = req_byte_offset - OFF_W'(SINGLE_SZ);
   assign dir_idx    = HDR_W'(req_byte_offset >> SB_SHIFT);
   assign sgl_idx    = ENT_IDX_W'(rel_single >> SB_SHIFT);
   assign dbl_outer  = ENT_IDX_W'(rel_double >> SPAN_SHIFT);
   assign dbl_inner  = ENT_IDX_W'(rel_double >> SB_SHIFT);
   assign sgl_ptr    = hdr_ff[SINGLE_SLOT];
   assign dbl_ptr    = hdr_ff[DOUBLE_SLOT];

   assign hdr_we = accept & (req_mode == MODE_HDR_WR) & (32'(req_header_slot) < HDR_DEPTH);

   always_ff @(posedge clock) begin
      if (hdr_we) begin
         hdr_ff[HDR_W'(req_header_slot)] <= req_sector_value;
      end
   end

   always_comb begin
      jobq_push      = 1'b0;
      jobq_job.op    = OP_DIRECT;
      jobq_job.level = LVL_DIRECT;
      jobq_job.oor   = 1'b0;
      jobq_job.addr  = '0;
      jobq_job.inner = '0;
      jobq_job.data  = '0;
      case (req_mode)
         MODE_IDX_WR: begin
            jobq_push = accept & (32'(req_table_sector) < NUM_SECTORS)
                        & (32'(req_table_entry) < ENTRIES_PER_TABLE);
            jobq_job.op   = OP_WRITE;
            jobq_job.addr = {req_table_sector[SEC_IDX_W-1:0],
                             req_table_entry[ENT_IDX_W-1:0]};
            jobq_job.data = req_sector_value;
         end
         MODE_XLATE: begin
            jobq_push = accept;
            if (32'(req_byte_offset) < DIRECT_SZ) begin
               jobq_job.data = hdr_ff[dir_idx];
            end else if (32'(req_byte_offset) < SINGLE_SZ) begin
               jobq_job.level = LVL_SINGLE;
               if (32'(sgl_ptr) < NUM_SECTORS) begin
                  jobq_job.op   = OP_SINGLE;
                  jobq_job.addr = {sgl_ptr[SEC_IDX_W-1:0], sgl_idx};
               end
            end else if (32'(req_byte_offset) < DOUBLE_SZ) begin
               jobq_job.level = LVL_DOUBLE;
               jobq_job.inner = dbl_inner;
               if (32'(dbl_ptr) < NUM_SECTORS) begin
                  jobq_job.op   = OP_DOUBLE;
                  jobq_job.addr = {dbl_ptr[SEC_IDX_W-1:0], dbl_outer};
               end
            end else begin
               jobq_job.oor = 1'b1;
            end
         end
         default: begin
            jobq_push = 1'b0;
         end
      endcase
   end

endmodule

// ===== hw/rtl/fotsw_job_queue.sv =====
`timescale 1ns / 1ps

module fotsw_job_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  fotsw_pkg::job_type push_job,
   output logic               full,
   input  logic               pop,
   output logic               head_valid,
   output fotsw_pkg::job_type head_job
);
   import fotsw_pkg::*;

   job_type               slot_ff [JOBQ_DEPTH];
   logic [JOBQ_PTR_W-1:0] wr_ptr_ff;
   logic [JOBQ_PTR_W-1:0] wr_ptr_in;
   logic [JOBQ_PTR_W-1:0] rd_ptr_ff;
   logic [JOBQ_PTR_W-1:0] rd_ptr_in;
   logic [JOBQ_PTR_W:0]   count_ff;
   logic [JOBQ_PTR_W:0]   count_in;
   logic                  do_push;
   logic                  do_pop;

   assign full       = (32'(count_ff) == JOBQ_DEPTH);
   assign head_valid = (count_ff != '0);
   assign head_job   = slot_ff[rd_ptr_ff];
   assign do_push    = push & ~full;
   assign do_pop     = pop & head_valid;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push & ~do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop & ~do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

// ===== hw/rtl/fotsw_back.sv =====
`timescale 1ns / 1ps

module fotsw_back (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         job_valid,
   input  fotsw_pkg::job_type           job,
   output logic                         job_pop,
   output logic                         rsp_empty,
   input  logic                         rsp_pop,
   output logic [fotsw_pkg::SEC_W-1:0]  rsp_sector,
   output logic [fotsw_pkg::LVL_W-1:0]  rsp_level,
   output logic                         rsp_out_of_range
);
   import fotsw_pkg::*;

   logic [SEC_W-1:0]      index_mem [STORE_DEPTH];
   logic [SEC_W-1:0]      rd_ff;
   logic [ADDR_W-1:0]     mem_addr;
   logic                  mem_we;

   logic                  s1_vld_ff, s1_vld_in;
   logic                  s1_mem_ff, s1_mem_in;
   logic                  s1_chain_ff, s1_chain_in;
   logic [ENT_IDX_W-1:0]  s1_inner_ff, s1_inner_in;
   logic [LVL_W-1:0]      s1_level_ff, s1_level_in;
   logic                  s1_oor_ff, s1_oor_in;
   logic [SEC_W-1:0]      s1_sector_ff, s1_sector_in;

   logic                  chain_now;
   logic                  mid_bad;
   logic                  credit_ok;

   rsp_type               rspq_ff [RSPQ_DEPTH];
   logic [RSPQ_PTR_W-1:0] rq_wr_ff, rq_wr_in;
   logic [RSPQ_PTR_W-1:0] rq_rd_ff, rq_rd_in;
   logic [RSPQ_PTR_W:0]   rq_cnt_ff, rq_cnt_in;
   logic                  rq_push;
   logic                  rq_pop;
   rsp_type               rq_data;
   rsp_type               rq_head;

   assign chain_now = s1_vld_ff & s1_chain_ff;
   assign mid_bad   = (32'(rd_ff) >= NUM_SECTORS);
   assign credit_ok = (32'(rq_cnt_ff) + 32'(s1_vld_ff)) < RSPQ_DEPTH;
   assign job_pop   = job_valid & ~chain_now & credit_ok;

   // memory port: second read of a double walk wins over a new beat
   always_comb begin
      mem_we   = 1'b0;
      mem_addr = job.addr;
      if (chain_now) begin
         mem_addr = {rd_ff[SEC_IDX_W-1:0], s1_inner_ff};
      end else if (job_pop && job.op == OP_WRITE) begin
         mem_we = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         index_mem[mem_addr] <= job.data;
      end
      rd_ff <= index_mem[mem_addr];
   end

   always_comb begin
      s1_vld_in    = 1'b0;
      s1_mem_in    = s1_mem_ff;
      s1_chain_in  = 1'b0;
      s1_inner_in  = s1_inner_ff;
      s1_level_in  = s1_level_ff;
      s1_oor_in    = s1_oor_ff;
      s1_sector_in = s1_sector_ff;
      if (chain_now) begin
         s1_vld_in    = 1'b1;
         s1_mem_in    = ~mid_bad;
         s1_sector_in = '0;
      end else if (job_pop && job.op != OP_WRITE) begin
         s1_vld_in    = 1'b1;
         s1_mem_in    = (job.op == OP_SINGLE) | (job.op == OP_DOUBLE);
         s1_chain_in  = (job.op == OP_DOUBLE);
         s1_inner_in  = job.inner;
         s1_level_in  = job.level;
         s1_oor_in    = job.oor;
         s1_sector_in = job.data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff   <= 1'b0;
         s1_chain_ff <= 1'b0;
      end else begin
         s1_vld_ff   <= s1_vld_in;
         s1_chain_ff <= s1_chain_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_mem_ff    <= s1_mem_in;
      s1_inner_ff  <= s1_inner_in;
      s1_level_ff  <= s1_level_in;
      s1_oor_ff    <= s1_oor_in;
      s1_sector_ff <= s1_sector_in;
   end

   // result queue
   assign rq_push        = s1_vld_ff & ~s1_chain_ff;
   assign rq_data.sector = s1_mem_ff ? rd_ff : s1_sector_ff;
   assign rq_data.level  = s1_level_ff;
   assign rq_data.oor    = s1_oor_ff;
   assign rsp_empty      = (rq_cnt_ff == '0);
   assign rq_pop         = rsp_pop & ~rsp_empty;
   assign rq_head        = rspq_ff[rq_rd_ff];

   assign rsp_sector       = rq_head.sector;
   assign rsp_level        = rq_head.level;
   assign rsp_out_of_range = rq_head.oor;

   always_comb begin
      rq_wr_in  = rq_push ? rq_wr_ff + 1'b1 : rq_wr_ff;
      rq_rd_in  = rq_pop ? rq_rd_ff + 1'b1 : rq_rd_ff;
      rq_cnt_in = rq_cnt_ff;
      if (rq_push & ~rq_pop) begin
         rq_cnt_in = rq_cnt_ff + 1'b1;
      end else if (rq_pop & ~rq_push) begin
         rq_cnt_in = rq_cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rq_wr_ff  <= '0;
         rq_rd_ff  <= '0;
         rq_cnt_ff <= '0;
      end else begin
         rq_wr_ff  <= rq_wr_in;
         rq_rd_ff  <= rq_rd_in;
         rq_cnt_ff <= rq_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rq_push) begin
         rspq_ff[rq_wr_ff] <= rq_data;
      end
   end

endmodule
